// File: rtl/core/bapw_pkg.sv
// Shared types, constants and field codes for the block average writer.
`default_nettype none

package bapw_pkg;

  // Block and buffer geometry.
  localparam int BLOCK_LEN  = 50;
  localparam int PAGE_DEPTH = 200;

  // Field and state widths.
  localparam int KIND_W = 2;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 6;
  localparam int SUM_W  = 22;
  localparam int ADDR_W = 9;

  // Constant divider: exact reciprocal multiply for magnitudes below 2**MAG_W.
  localparam int MAG_W     = SUM_W - 1;
  localparam int MULT_W    = MAG_W + 1;
  localparam int PROD_W    = MAG_W + MULT_W;
  localparam int DIV_SHIFT = MAG_W + $clog2(BLOCK_LEN);
  localparam int QUO_W     = PROD_W - DIV_SHIFT;
  localparam longint unsigned DIV_MULT_L =
    ((64'd1 << DIV_SHIFT) + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SAMPLE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HOST_RST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLR_PAGE1 = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLR_PAGE2 = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                    write_valid;
    logic [ADDR_W-1:0]       write_address;
    logic signed [VAL_W-1:0] write_value;
    logic                    page_one_full;
    logic                    page_two_full;
  } out_item_t;

  // Finished block from the accumulator stage, handed to the output stage.
  typedef struct packed {
    logic                    wrote;
    logic [ADDR_W-1:0]       addr;
    logic signed [SUM_W-1:0] sum;
    logic                    page_one;
    logic                    page_two;
  } blk_res_t;

endpackage

`default_nettype wire

// File: rtl/core/bapw_div.sv
// Signed divide by the block length, truncating toward zero.
`default_nettype none

module bapw_div (
  input  wire logic signed [bapw_pkg::SUM_W-1:0] sum,
  output logic signed [bapw_pkg::VAL_W-1:0]      quotient
);
  import bapw_pkg::*;

  logic                    neg;
  logic [SUM_W-1:0]        mag_full;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [QUO_W-1:0]        quo;
  logic [VAL_W-1:0]        quo_t;

  // Work on the magnitude so the quotient truncates toward zero.
  assign neg      = sum[SUM_W-1];
  assign mag_full = neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag      = mag_full[MAG_W-1:0];

  // Reciprocal multiply; the rounded-up constant makes the result exact.
  assign prod  = PROD_W'(mag) * PROD_W'(DIV_MULT);
  assign quo   = prod[PROD_W-1:DIV_SHIFT];
  assign quo_t = VAL_W'(quo);

  // Restore the sign.
  assign quotient = neg ? VAL_W'(-quo_t) : quo_t;

endmodule

`default_nettype wire

// File: rtl/core/block_average_ping_pong_writer_unit.sv
// Top level: sample accumulator, page bookkeeping and result register.
// Path from item accept to result valid: input register, accumulator stage
// register, then divider into the output register.
// Throughput: one item per cycle; the three stages advance together whenever
// the output register is empty or its item is being taken.
// Reset: synchronous active-low rst_n clears all stage valids, the sample
// count, block sum, write index, active page and both full flags.
`default_nettype none

module block_average_ping_pong_writer_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bapw_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bapw_pkg::out_item_t       out_data
);
  import bapw_pkg::*;

  localparam logic [CNT_W-1:0]  BLK_END   = CNT_W'(BLOCK_LEN);
  localparam logic [ADDR_W-1:0] PAGE1_END = ADDR_W'(PAGE_DEPTH);
  localparam logic [ADDR_W-1:0] PAGE2_END = ADDR_W'(2 * PAGE_DEPTH);

  logic adv;

  // Input register.
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Accumulator state.
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [ADDR_W-1:0]       idx_r, idx_nxt;
  logic                    page2_r, page2_nxt;
  logic                    flag1_r, flag1_nxt;
  logic                    flag2_r, flag2_nxt;

  // Accumulator stage result.
  logic     s2_valid_r;
  blk_res_t s2_res_r, s2_res_nxt;

  // Output register.
  logic                    out_valid_r;
  out_item_t               out_data_r;
  logic signed [VAL_W-1:0] avg;

  // Whole pipeline moves unless a held result is being stalled.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
    if (adv) begin
      s1_item_r <= in_data;
    end
  end

  // Accumulate samples, close blocks and track the pages.
  logic signed [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0]        cnt_inc;
  logic [ADDR_W-1:0]       idx_inc;

  always_comb begin
    sum_add    = sum_r + SUM_W'(s1_item_r.sample);
    cnt_inc    = cnt_r + CNT_W'(1);
    idx_inc    = idx_r + ADDR_W'(1);
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    page2_nxt  = page2_r;
    flag1_nxt  = flag1_r;
    flag2_nxt  = flag2_r;
    s2_res_nxt = '0;
    case (s1_item_r.kind)
      KIND_SAMPLE: begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= BLK_END) begin
          s2_res_nxt.wrote = 1'b1;
          s2_res_nxt.addr  = idx_r;
          s2_res_nxt.sum   = sum_add;
          idx_nxt          = idx_inc;
          sum_nxt          = '0;
          cnt_nxt          = '0;
          if (!page2_r) begin
            if (idx_inc >= PAGE1_END) begin
              flag1_nxt = 1'b1;
              page2_nxt = 1'b1;
            end
          end else if (idx_inc >= PAGE2_END) begin
            flag2_nxt = 1'b1;
            idx_nxt   = '0;
            page2_nxt = 1'b0;
          end
        end
      end
      KIND_HOST_RST: begin
        cnt_nxt   = '0;
        sum_nxt   = '0;
        idx_nxt   = '0;
        page2_nxt = 1'b0;
        flag1_nxt = 1'b0;
        flag2_nxt = 1'b0;
      end
      KIND_CLR_PAGE1: begin
        flag1_nxt = 1'b0;
      end
      KIND_CLR_PAGE2: begin
        flag2_nxt = 1'b0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    s2_res_nxt.page_one = flag1_nxt;
    s2_res_nxt.page_two = flag2_nxt;
  end

  // Accumulator state and stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      idx_r      <= '0;
      page2_r    <= 1'b0;
      flag1_r    <= 1'b0;
      flag2_r    <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
        idx_r   <= idx_nxt;
        page2_r <= page2_nxt;
        flag1_r <= flag1_nxt;
        flag2_r <= flag2_nxt;
      end
    end
    if (adv) begin
      s2_res_r <= s2_res_nxt;
    end
  end

  // Block average.
  bapw_div u_div (
    .sum      (s2_res_r.sum),
    .quotient (avg)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
    if (adv) begin
      out_data_r.write_valid   <= s2_res_r.wrote;
      out_data_r.write_address <= s2_res_r.addr;
      out_data_r.write_value   <= s2_res_r.wrote ? avg : '0;
      out_data_r.page_one_full <= s2_res_r.page_one;
      out_data_r.page_two_full <= s2_res_r.page_two;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sample count never reaches the block length between items.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < BLK_END)
    else $error("sample count reached block length");

  // The active page always matches the half the write index lies in.
  a_page_match: assert property (@(posedge clk) disable iff (!rst_n)
    page2_r == (idx_r >= PAGE1_END))
    else $error("active page disagrees with write index");

  // A host reset item leaves the block at its start and clears both full flags.
  a_host_rst: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && s1_item_r.kind == KIND_HOST_RST) |=>
    (cnt_r == '0 && sum_r == '0 && idx_r == '0 && !page2_r && !flag1_r && !flag2_r))
    else $error("host reset did not clear the block");

  // Written addresses stay inside the buffer.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.write_valid) |-> (out_data_r.write_address < PAGE2_END))
    else $error("write address beyond buffer");

  // An item without a write carries zero address and value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.write_valid) |->
    (out_data_r.write_address == '0 && out_data_r.write_value == '0))
    else $error("non-write item carries address or value");

endmodule

`default_nettype wire
